>>> hw/rtl/mfpf_pkg.sv
package mfpf_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 32;

  localparam int ROW_BYTES   = (SCREEN_WIDTH + 7) / 8;
  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = ROW_BYTES * SCREEN_HEIGHT;

  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int OFF_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int COL_W  = $clog2(SCREEN_WIDTH);
  localparam int ROW_W  = $clog2(PAGE_COUNT * 8);

  // fixed field widths of the item ports
  localparam int PIX_X_W = 7;
  localparam int PIX_Y_W = 5;

  localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;

  localparam logic ACTION_PIXEL = 1'b0;
  localparam logic ACTION_FLUSH = 1'b1;

  typedef struct packed {
    logic clr_wr;
    logic in_load;
    logic pix_rd;
    logic pix_wr;
    logic gather_rd;
    logic out_load;
  } mfpf_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_action;
    logic in_pix_ok;
    logic pos_is_cmd;
    logic gather_last;
    logic out_free;
  } mfpf_sts_t;

endpackage

>>> hw/rtl/mfpf_datapath.sv
module mfpf_datapath import mfpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mfpf_cmd_t          cmd_i,
  output mfpf_sts_t          sts_o,
  input  logic               action_i,
  input  logic [PIX_X_W-1:0] pixel_x_i,
  input  logic [PIX_Y_W-1:0] pixel_y_i,
  input  logic               pixel_on_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               is_command_o,
  output logic               last_o
);

  logic [7:0] mem_q [STORE_BYTES];
  logic [7:0] rdata_q;

  logic [ADDR_W-1:0]  clr_addr_q, clr_addr_d;
  logic [PIX_X_W-1:0] pix_x_q;
  logic [PIX_Y_W-1:0] pix_y_q;
  logic               pix_on_q;

  logic [PAGE_W-1:0] page_q, page_d;
  logic [OFF_W-1:0]  offset_q, offset_d;
  logic [2:0]        cnt_q, cnt_d;

  logic       cap_en_q;
  logic [2:0] cap_idx_q;
  logic       cap_ok_q;
  logic [7:0] data_sr_q;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       is_command_q;
  logic       last_q;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              row_ok;
  logic [ADDR_W-1:0] pix_addr;
  logic [ADDR_W-1:0] gather_addr;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;
  logic [7:0]        pix_mask;
  logic              is_cmd;
  logic              page_end;
  logic              last_page;

  assign is_cmd    = (offset_q == '0);
  assign page_end  = (offset_q == OFF_W'(SCREEN_WIDTH));
  assign last_page = (page_q == PAGE_W'(PAGE_COUNT - 1));

  // data byte c of a page is column c, at stream offset c + 1
  assign col      = COL_W'(offset_q - OFF_W'(1));
  assign row      = ROW_W'(int'(page_q) * 8 + int'(cnt_q));
  assign row_ok   = (int'(row) < SCREEN_HEIGHT);
  assign pix_addr = ADDR_W'(int'(pix_y_q) * ROW_BYTES + int'(pix_x_q >> 3));
  assign gather_addr = ADDR_W'(int'(row) * ROW_BYTES + int'(col >> 3));
  assign pix_mask = 8'(1) << pix_x_q[2:0];

  always_comb begin
    if (cmd_i.clr_wr) begin
      mem_addr = clr_addr_q;
    end else if (cmd_i.pix_rd || cmd_i.pix_wr) begin
      mem_addr = pix_addr;
    end else begin
      mem_addr = gather_addr;
    end
  end

  assign mem_we    = cmd_i.clr_wr | cmd_i.pix_wr;
  assign mem_wdata = cmd_i.clr_wr ? 8'h00 :
                     (pix_on_q ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  assign clr_addr_d = cmd_i.clr_wr ? clr_addr_q + ADDR_W'(1) : clr_addr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.in_load) begin
      cnt_d = '0;
    end else if (cmd_i.gather_rd) begin
      cnt_d = cnt_q + 3'd1;
    end
  end

  always_comb begin
    page_d   = page_q;
    offset_d = offset_q;
    if (cmd_i.out_load) begin
      if (page_end) begin
        offset_d = '0;
        page_d   = last_page ? '0 : page_q + PAGE_W'(1);
      end else begin
        offset_d = offset_q + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      page_q      <= '0;
      offset_q    <= '0;
      cnt_q       <= '0;
      cap_en_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      clr_addr_q <= clr_addr_d;
      page_q     <= page_d;
      offset_q   <= offset_d;
      cnt_q      <= cnt_d;
      cap_en_q   <= cmd_i.gather_rd;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      pix_x_q  <= pixel_x_i;
      pix_y_q  <= pixel_y_i;
      pix_on_q <= pixel_on_i;
    end
    cap_idx_q <= cnt_q;
    cap_ok_q  <= row_ok;
    // read data lands in the cycle after the address; rows past the screen read as 0
    if (cap_en_q) begin
      data_sr_q[cap_idx_q] <= cap_ok_q & rdata_q[col[2:0]];
    end
    if (cmd_i.out_load) begin
      out_byte_q   <= is_cmd ? (PAGE_CMD_BASE + 8'(page_q)) : data_sr_q;
      is_command_q <= is_cmd;
      last_q       <= ~is_cmd & page_end & last_page;
    end
  end

  assign sts_o.clr_last    = (clr_addr_q == ADDR_W'(STORE_BYTES - 1));
  assign sts_o.in_action   = action_i;
  assign sts_o.in_pix_ok   = (int'(pixel_x_i) < SCREEN_WIDTH) &&
                             (int'(pixel_y_i) < SCREEN_HEIGHT);
  assign sts_o.pos_is_cmd  = is_cmd;
  assign sts_o.gather_last = (cnt_q == 3'd7);
  assign sts_o.out_free    = ~out_valid_q | out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_command_o = is_command_q;
  assign last_o       = last_q;

endmodule

>>> hw/rtl/mfpf_ctrl.sv
module mfpf_ctrl import mfpf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mfpf_sts_t sts_i,
  output mfpf_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PIX_RD = 3'd2;
  localparam logic [2:0] S_PIX_WR = 3'd3;
  localparam logic [2:0] S_GATHER = 3'd4;
  localparam logic [2:0] S_GFIN   = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd_o.in_load = 1'b1;
          if (sts_i.in_action == ACTION_FLUSH) begin
            state_d = sts_i.pos_is_cmd ? S_EMIT : S_GATHER;
          end else if (sts_i.in_pix_ok) begin
            state_d = S_PIX_RD;
          end
        end
      end
      S_PIX_RD: begin
        cmd_o.pix_rd = 1'b1;
        state_d      = S_PIX_WR;
      end
      S_PIX_WR: begin
        cmd_o.pix_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_GATHER: begin
        cmd_o.gather_rd = 1'b1;
        if (sts_i.gather_last) begin
          state_d = S_GFIN;
        end
      end
      S_GFIN: begin
        // last row byte is captured at this edge
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/mono_framebuffer_page_flush.sv
// Set-pixel transaction: accept, byte read, byte write; no result.
// Flush transaction: after accept the result loads as a command byte, or as a data byte
// after 8 frame memory reads; the load waits while the output register is full.
// One transaction at a time; a result waits in the output register while the next is taken.
// After reset a clearing pass zeroes the 512-byte frame memory, one byte per cycle,
// so in_ready_o stays low until the pass ends; the flush position resets to page 0.
module mono_framebuffer_page_flush import mfpf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic [PIX_X_W-1:0] pixel_x_i,
  input  logic [PIX_Y_W-1:0] pixel_y_i,
  input  logic               pixel_on_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               is_command_o,
  output logic               last_o
);

  mfpf_cmd_t cmd;
  mfpf_sts_t sts;

  mfpf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mfpf_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .action_i     (action_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_on_i   (pixel_on_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o)
  );

endmodule

>>> bench/tb_mono_framebuffer_page_flush.sv
module tb_mono_framebuffer_page_flush;
  import mfpf_pkg::*;

  localparam int PAGE_SPAN   = SCREEN_WIDTH + 1;
  localparam int STREAM_LEN  = PAGE_COUNT * PAGE_SPAN;
  localparam int ITEM_TARGET = 1700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       last;
  } flush_byte_t;

  // Shadow of the frame store plus the flush pointer; predicts each flush byte
  // at the moment the flush step is accepted.
  class flush_scoreboard;
    logic [7:0]  pixel_mem [STORE_BYTES];
    int unsigned stream_pos;
    flush_byte_t pending [$];
    int errors;
    int checked;
    int commands;
    int flushes;
    int pixel_writes;

    function new();
      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      stream_pos   = 0;
      errors       = 0;
      checked      = 0;
      commands     = 0;
      flushes      = 0;
      pixel_writes = 0;
    endfunction

    function void note_item(logic act, logic [PIX_X_W-1:0] x, logic [PIX_Y_W-1:0] y,
                            logic on);
      int unsigned idx;
      int unsigned page;
      int unsigned off;
      int unsigned row;
      flush_byte_t want;
      if (act == ACTION_PIXEL) begin
        if (x < SCREEN_WIDTH && y < SCREEN_HEIGHT) begin
          idx = y * ROW_BYTES + (x >> 3);
          pixel_mem[idx][x[2:0]] = on;
          pixel_writes++;
        end
      end else begin
        page = stream_pos / PAGE_SPAN;
        off  = stream_pos % PAGE_SPAN;
        want = '0;
        if (off == 0) begin
          want.data = PAGE_CMD_BASE + 8'(page);
          want.cmd  = 1'b1;
        end else begin
          for (int i = 0; i < 8; i++) begin
            row = page * 8 + i;
            // rows past the screen bottom read dark
            if (row < SCREEN_HEIGHT)
              want.data[i] = pixel_mem[row * ROW_BYTES + ((off - 1) >> 3)][(off - 1) % 8];
          end
          want.last = (stream_pos == STREAM_LEN - 1);
        end
        pending.push_back(want);
        stream_pos = (stream_pos == STREAM_LEN - 1) ? 0 : stream_pos + 1;
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_byte(logic [7:0] b, logic c, logic l);
      flush_byte_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("byte %02h with no flush step pending", b));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (b !== want.data)
        report_mismatch($sformatf("out_byte %02h, want %02h (result %0d)", b, want.data, checked));
      if (c !== want.cmd)
        report_mismatch($sformatf("is_command %b, want %b (result %0d)", c, want.cmd, checked));
      if (l !== want.last)
        report_mismatch($sformatf("last %b, want %b (result %0d)", l, want.last, checked));
      if (want.cmd) commands++;
      if (want.last) flushes++;
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               action_i = ACTION_PIXEL;
  logic [PIX_X_W-1:0] pixel_x_i = '0;
  logic [PIX_Y_W-1:0] pixel_y_i = '0;
  logic               pixel_on_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         out_byte_o;
  logic               is_command_o;
  logic               last_o;

  flush_scoreboard sb = new();
  int  items_sent  = 0;
  int  cycle_count = 0;
  bit  steady      = 1'b0;

  mono_framebuffer_page_flush uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .pixel_on_i   (pixel_on_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random backpressure, none inside the steady window
  always @(negedge clk_i) begin
    if (rst_ni)
      out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_byte(out_byte_o, is_command_o, last_o);
  end

  // Called at a falling edge; returns at the falling edge after the item is accepted.
  task send_item(logic act, logic [PIX_X_W-1:0] x, logic [PIX_Y_W-1:0] y, logic on);
    steady = (items_sent >= 800 && items_sent < 1100);
    if (!steady) begin
      while ($urandom_range(99) < 38) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    pixel_x_i  <= x;
    pixel_y_i  <= y;
    pixel_on_i <= on;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(act, x, y, on);
    items_sent++;
    @(negedge clk_i);
  endtask

  task set_pixel(int x, int y, logic on);
    send_item(ACTION_PIXEL, PIX_X_W'(x), PIX_Y_W'(y), on);
  endtask

  task flush_step();
    send_item(ACTION_FLUSH, PIX_X_W'($urandom), PIX_Y_W'($urandom), 1'($urandom));
  endtask

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners, both pixel polarities, then the first bytes of page 0
    set_pixel(0, 0, 1'b1);
    set_pixel(127, 31, 1'b1);
    set_pixel(127, 0, 1'b1);
    set_pixel(0, 31, 1'b1);
    set_pixel(0, 7, 1'b1);
    set_pixel(5, 7, 1'b1);
    set_pixel(5, 7, 1'b0);
    set_pixel(1, 3, 1'b1);
    flush_step();
    flush_step();
    flush_step();
    // change a column not yet gathered and one already gathered in the middle of the flush
    set_pixel(2, 6, 1'b1);
    set_pixel(1, 3, 1'b0);
    flush_step();
    flush_step();
    set_pixel(3, 0, 1'b1);
    set_pixel(3, 0, 1'b0);
    flush_step();

    // bursts of drawing followed by runs of flush steps
    while (items_sent < ITEM_TARGET) begin
      n = $urandom_range(1, 12);
      repeat (n)
        send_item(ACTION_PIXEL, PIX_X_W'($urandom_range(SCREEN_WIDTH - 1)),
                  PIX_Y_W'($urandom_range(SCREEN_HEIGHT - 1)), 1'($urandom));
      n = $urandom_range(1, 160);
      repeat (n) flush_step();
    end
    in_valid_i <= 1'b0;
    steady = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d items sent: %0d pixel writes, %0d flush bytes checked", items_sent,
             sb.pixel_writes, sb.checked);
    $display("%0d page commands, %0d complete flushes, %0d mismatches", sb.commands,
             sb.flushes, sb.errors);
    if (sb.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mfpf_pkg.sv
hw/rtl/mfpf_datapath.sv
hw/rtl/mfpf_ctrl.sv
hw/rtl/mono_framebuffer_page_flush.sv
bench/tb_mono_framebuffer_page_flush.sv
